[sv/assert_macros.svh]
// Assertion helpers used by the checker file frp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define FRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, gated off while reset is asserted.
`define FRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[sv/frp_pkg.sv]
`default_nettype none

package frp_pkg;

  // Field kind codes carried on each result.
  typedef enum logic [3:0] {
    KIND_ROWID    = 4'd0,
    KIND_FLAGS    = 4'd1,
    KIND_CODELEN  = 4'd2,
    KIND_CODE     = 4'd3,
    KIND_FP16LEN  = 4'd4,
    KIND_FP16     = 4'd5,
    KIND_BIAS     = 4'd6,
    KIND_FILTLEN  = 4'd7,
    KIND_FILTER   = 4'd8,
    KIND_PAYLOAD  = 4'd9,
    KIND_DISCARD  = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_TRUNC = 3'd2,
    ST_ODD   = 3'd3,
    ST_TRAIL = 3'd4
  } status_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CFG_CODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FP16    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIAS    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FILTER  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PAYLOAD = 3'd4;

  localparam int unsigned FifoDepth = 4;

  typedef struct packed {
    logic [3:0] code_bit;
    logic [3:0] fp16_bit;
    logic [3:0] bias_bit;
    logic [3:0] filter_bit;
    logic [3:0] payload_bit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    code_bit:    4'd0,
    fp16_bit:    4'd1,
    bias_bit:    4'd2,
    filter_bit:  4'd3,
    payload_bit: 4'd4
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [3:0]  field_kind;
    logic [31:0] offset_in_field;
    logic        record_done;
    logic [2:0]  status;
    logic [63:0] row_id_value;
    logic [15:0] flag_word;
    logic [15:0] bias_value;
    logic        bias_present;
  } out_t;

endpackage

`default_nettype wire

[sv/flagged_record_field_parser.sv]
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  frp_pkg::in_t  (byte, last flag)
// out       output     out_valid_o/out_stall_i frp_pkg::out_t (tagged byte)
// cfg       input      cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// Sustained rate is one byte per cycle while the output is not stalled; the
// parser step is a state update on the byte at the head of the intake queue.
// From input accept to output valid a byte passes the queue, then the
// output register. The intake queue holds FIFO_DEPTH bytes.
// Reset is asynchronous, active low; flag-bit registers return to 0..4.
// An output stall holds the result register; input keeps flowing into the
// queue until it is full, at which point in_stall_o rises.
`default_nettype none

module flagged_record_field_parser #(
  parameter int unsigned FIFO_DEPTH = frp_pkg::FifoDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // byte requests in
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire frp_pkg::in_t                  in_data_i,
  // tagged byte requests out
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output frp_pkg::out_t                      out_data_o,
  // register writes
  input  wire logic                          cfg_we_i,
  input  wire logic [frp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [frp_pkg::CfgDataW-1:0]  cfg_data_i
);

  frp_pkg::cfg_t cfg_q;
  logic          q_valid;
  logic          q_pop;
  frp_pkg::in_t  q_data;

  // Flag-bit position registers; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= frp_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        frp_pkg::CFG_CODE:    cfg_q.code_bit    <= cfg_data_i;
        frp_pkg::CFG_FP16:    cfg_q.fp16_bit    <= cfg_data_i;
        frp_pkg::CFG_BIAS:    cfg_q.bias_bit    <= cfg_data_i;
        frp_pkg::CFG_FILTER:  cfg_q.filter_bit  <= cfg_data_i;
        frp_pkg::CFG_PAYLOAD: cfg_q.payload_bit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: intake queue decouples the sender from parser/output stalls.
  frp_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (in_data_i),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data)
  );

  // Back: field tracking, error capture and the result register.
  frp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (q_valid),
    .byte_pop_o   (q_pop),
    .byte_i       (q_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

[sv/frp_fifo.sv]
`default_nettype none

// Small register queue between intake and parser.
module frp_fifo #(
  parameter int unsigned DEPTH = frp_pkg::FifoDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_stall_o,
  input  wire frp_pkg::in_t push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_i,
  output frp_pkg::in_t      pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  frp_pkg::in_t        mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_stall_o = (count_q == CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[sv/frp_parser.sv]
`default_nettype none

// Record parser: one byte per cycle from queue to output register unless stalled.
module frp_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire frp_pkg::cfg_t cfg_i,
  input  wire logic          byte_valid_i,
  output logic               byte_pop_o,
  input  wire frp_pkg::in_t  byte_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output frp_pkg::out_t      out_data_o
);

  typedef enum logic [3:0] {
    PH_ROWID   = 4'd0,
    PH_FLAGS   = 4'd1,
    PH_CODELEN = 4'd2,
    PH_CODE    = 4'd3,
    PH_FP16LEN = 4'd4,
    PH_FP16    = 4'd5,
    PH_BIAS    = 4'd6,
    PH_FILTLEN = 4'd7,
    PH_FILTER  = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_DISCARD = 4'd10,
    PH_END     = 4'd11
  } phase_e;

  // First present field at or after group k (0 code .. 4 payload).
  function automatic phase_e next_field(logic [15:0] flg, frp_pkg::cfg_t cfg,
                                        logic [2:0] k);
    phase_e res;
    res = PH_END;
    if (k <= 3'd4 && flg[cfg.payload_bit]) res = PH_PAYLOAD;
    if (k <= 3'd3 && flg[cfg.filter_bit])  res = PH_FILTLEN;
    if (k <= 3'd2 && flg[cfg.bias_bit])    res = PH_BIAS;
    if (k <= 3'd1 && flg[cfg.fp16_bit])    res = PH_FP16LEN;
    if (k == 3'd0 && flg[cfg.code_bit])    res = PH_CODELEN;
    return res;
  endfunction

  function automatic logic [2:0] group_after(phase_e ph);
    logic [2:0] g;
    case (ph)
      PH_CODELEN, PH_CODE: g = 3'd1;
      PH_FP16LEN, PH_FP16: g = 3'd2;
      default:             g = 3'd4;
    endcase
    return g;
  endfunction

  function automatic phase_e data_phase(phase_e ph);
    phase_e d;
    case (ph)
      PH_CODELEN: d = PH_CODE;
      PH_FP16LEN: d = PH_FP16;
      default:    d = PH_FILTER;
    endcase
    return d;
  endfunction

  phase_e        phase_q, phase_d, ph;
  logic [31:0]   off_q, off_d, off, cur_off;
  logic [31:0]   len_q, len_d, len;
  logic [63:0]   row_q, row_d, row;
  logic [15:0]   flags_q, flags_d, flg;
  logic [15:0]   bias_q, bias_d, bias;
  logic          seen_q, seen_d, seen;
  logic [2:0]    err_q, err_d, err;
  logic          moved;
  logic [3:0]    kind;
  logic [7:0]    b;
  logic          load_ok;
  frp_pkg::out_t res;
  frp_pkg::out_t out_q;
  logic          out_valid_q;

  assign b           = byte_i.data_byte;
  assign load_ok     = !out_valid_q || !out_stall_i;
  assign byte_pop_o  = byte_valid_i && load_ok;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ph    = phase_q;
    off   = off_q;
    len   = len_q;
    row   = row_q;
    flg   = flags_q;
    bias  = bias_q;
    seen  = seen_q;
    err   = err_q;
    moved = 1'b0;

    // all fields done: any further byte is trailing garbage
    if (ph == PH_END) begin
      if (err == frp_pkg::ST_OK) err = frp_pkg::ST_TRAIL;
      ph  = PH_DISCARD;
      off = '0;
      len = '0;
    end
    kind    = 4'(ph);
    cur_off = off;

    case (ph)
      PH_ROWID: begin
        row[{off[2:0], 3'b000} +: 8] = row[{off[2:0], 3'b000} +: 8] | b;
        if (off >= 32'd7) begin
          ph = PH_FLAGS; off = '0; len = '0; moved = 1'b1;
        end
      end
      PH_FLAGS: begin
        flg[{off[0], 3'b000} +: 8] = flg[{off[0], 3'b000} +: 8] | b;
        if (off >= 32'd1) begin
          ph = next_field(flg, cfg_i, 3'd0); off = '0; len = '0; moved = 1'b1;
        end
      end
      PH_CODELEN, PH_FP16LEN, PH_FILTLEN: begin
        len[{off[1:0], 3'b000} +: 8] = len[{off[1:0], 3'b000} +: 8] | b;
        if (off >= 32'd3) begin
          moved = 1'b1;
          off   = '0;
          if (ph == PH_FP16LEN && len[0]) begin
            if (err == frp_pkg::ST_OK) err = frp_pkg::ST_ODD;
            ph  = PH_DISCARD;
            len = '0;
          end else if (len == '0) begin
            ph = next_field(flg, cfg_i, group_after(ph));
          end else begin
            ph = data_phase(ph);
          end
        end
      end
      PH_CODE, PH_FP16, PH_FILTER: begin
        if (({1'b0, off} + 33'd1) >= {1'b0, len}) begin
          ph = next_field(flg, cfg_i, group_after(ph)); off = '0; len = '0;
          moved = 1'b1;
        end
      end
      PH_BIAS: begin
        bias[{off[0], 3'b000} +: 8] = bias[{off[0], 3'b000} +: 8] | b;
        if (off >= 32'd1) begin
          seen = 1'b1;
          ph = next_field(flg, cfg_i, 3'd3); off = '0; len = '0; moved = 1'b1;
        end
      end
      default: ;
    endcase

    // offset saturates at all ones
    if (!moved && off != '1) off = off + 32'd1;

    if (byte_i.last_byte && err == frp_pkg::ST_OK) begin
      if (ph == PH_ROWID || ph == PH_FLAGS) begin
        err = frp_pkg::ST_SHORT;
      end else if (ph != PH_PAYLOAD && ph != PH_END) begin
        err = frp_pkg::ST_TRUNC;
      end
    end

    res.data_out        = b;
    res.field_kind      = kind;
    res.offset_in_field = cur_off;
    res.record_done     = byte_i.last_byte;
    res.status          = byte_i.last_byte ? err : frp_pkg::ST_OK;
    res.row_id_value    = row;
    res.flag_word       = flg;
    res.bias_value      = bias;
    res.bias_present    = seen;

    if (byte_i.last_byte) begin
      phase_d = PH_ROWID;
      off_d   = '0;
      len_d   = '0;
      row_d   = '0;
      flags_d = '0;
      bias_d  = '0;
      seen_d  = 1'b0;
      err_d   = frp_pkg::ST_OK;
    end else begin
      phase_d = ph;
      off_d   = off;
      len_d   = len;
      row_d   = row;
      flags_d = flg;
      bias_d  = bias;
      seen_d  = seen;
      err_d   = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ROWID;
      off_q       <= '0;
      len_q       <= '0;
      row_q       <= '0;
      flags_q     <= '0;
      bias_q      <= '0;
      seen_q      <= 1'b0;
      err_q       <= frp_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (byte_pop_o) begin
        phase_q <= phase_d;
        off_q   <= off_d;
        len_q   <= len_d;
        row_q   <= row_d;
        flags_q <= flags_d;
        bias_q  <= bias_d;
        seen_q  <= seen_d;
        err_q   <= err_d;
      end
      if (load_ok) begin
        out_valid_q <= byte_pop_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_pop_o) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

[sv/frp_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module frp_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_o,
  input  wire frp_pkg::in_t                  in_data_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire frp_pkg::out_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [frp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [frp_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic out_take;
  logic after_done_q;
  logic unused_ok;

  assign out_take  = out_valid_o && !out_stall_i;
  assign unused_ok = ^{in_valid_i, in_stall_o, in_data_i, cfg_we_i, cfg_idx_i, cfg_data_i};

  // set after a record's last result went out; a new record starts next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_done_q <= 1'b1;
    end else if (out_take) begin
      after_done_q <= out_data_o.record_done;
    end
  end

  // status only reported on the record's last byte
  `FRP_ASSERT_IMP(a_status_at_end, clk_i, rst_ni, out_valid_o && !out_data_o.record_done, out_data_o.status == frp_pkg::ST_OK)

  `FRP_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, out_data_o.status <= frp_pkg::ST_TRAIL)

  // first byte of every record is row id byte zero
  `FRP_ASSERT_IMP(a_record_start, clk_i, rst_ni, out_take && after_done_q, out_data_o.field_kind == frp_pkg::KIND_ROWID && out_data_o.offset_in_field == 32'd0)

  `FRP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind flagged_record_field_parser frp_checker u_frp_checker (.*);

`default_nettype wire
